FILE: hw/rtl/differential_odometry_update_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the odometry update block
// Clocked property wrappers that report through $error.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_ODOMETRY_UPDATE_ASSERT_SVH
`define DIFFERENTIAL_ODOMETRY_UPDATE_ASSERT_SVH

// property checked outside reset
`define DOU_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define DOU_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/dou_pkg.sv
// ----------------------------------------------------------------------------
// dou_pkg
// Shared widths, constants and types of the odometry update block.
// ----------------------------------------------------------------------------
package dou_pkg;

	localparam int POS_W   = 48;
	localparam int CNT_W   = 32;
	localparam int DELTA_W = 33;
	localparam int GAIN_W  = 24;
	localparam int HEAD_W  = 16;
	localparam int SINE_W  = 16;

	localparam int unsigned HEADING_FULL = 36000;
	localparam int unsigned HEADING_HALF = 18000;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic signed [SINE_W-1:0] sin_v;
		logic signed [SINE_W-1:0] cos_v;
	} sincos_t;

endpackage

FILE: hw/rtl/dou_sine_lut.sv
// ----------------------------------------------------------------------------
// dou_sine_lut
// Q1.15 sine and cosine lookup from a quarter-wave constant table.
// ----------------------------------------------------------------------------
module dou_sine_lut #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic [SINE_TABLE_BITS-1:0] idx,
	output dou_pkg::sincos_t           sc
);

	localparam int TblN     = 1 << SINE_TABLE_BITS;
	localparam int QuarterN = TblN / 4;
	localparam int SelW     = SINE_TABLE_BITS - 1;

	function automatic logic [14:0] qsin(input int unsigned k);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        q;
		logic signed [63:0] sum;
		x    = (dou_pkg::HALF_PI_Q30 * 64'(k)) / 64'(QuarterN);
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum  = sum - $signed(term);
		if (sum < 0) begin
			sum = '0;
		end
		q = ($unsigned(sum) + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return q[14:0];
	endfunction

	logic [14:0] qtab [0:QuarterN];

	for (genvar k = 0; k <= QuarterN; k++) begin : g_tab
		assign qtab[k] = qsin(k);
	end

	logic [SINE_TABLE_BITS-1:0] cidx;
	logic [SelW-1:0]            sel_s;
	logic [SelW-1:0]            sel_c;
	logic [14:0]                mag_s;
	logic [14:0]                mag_c;

	always_comb begin
		cidx  = idx + SINE_TABLE_BITS'(QuarterN);
		sel_s = idx[SINE_TABLE_BITS-2] ?
			SelW'(QuarterN) - SelW'(idx[SINE_TABLE_BITS-3:0]) :
			SelW'(idx[SINE_TABLE_BITS-3:0]);
		sel_c = cidx[SINE_TABLE_BITS-2] ?
			SelW'(QuarterN) - SelW'(cidx[SINE_TABLE_BITS-3:0]) :
			SelW'(cidx[SINE_TABLE_BITS-3:0]);
		mag_s = qtab[sel_s];
		mag_c = qtab[sel_c];
		sc.sin_v = idx[SINE_TABLE_BITS-1] ?
			-$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
		sc.cos_v = cidx[SINE_TABLE_BITS-1] ?
			-$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
	end

endmodule

FILE: hw/rtl/differential_odometry_update.sv
// ----------------------------------------------------------------------------
// differential_odometry_update - differential-drive odometry, one sample a beat
// A sample passes stages s1, s2, s3 and s4 and then the result register.
// Throughput: one sample per cycle unless a held result stalls; only full stages stall.
// Reset clears gain, encoder references, position and all valid bits.
// ----------------------------------------------------------------------------
module differential_odometry_update #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                velocity_gain_we,
	input  logic [dou_pkg::GAIN_W-1:0]          velocity_gain,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic                                clear,
	input  logic [dou_pkg::HEAD_W-1:0]          heading_cdeg,
	input  logic signed [dou_pkg::CNT_W-1:0]    left_count,
	input  logic signed [dou_pkg::CNT_W-1:0]    right_count,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [dou_pkg::POS_W-1:0]    pos_x,
	output logic signed [dou_pkg::POS_W-1:0]    pos_y,
	output logic signed [dou_pkg::HEAD_W-1:0]   heading_signed,
	output logic signed [dou_pkg::POS_W-1:0]    left_velocity,
	output logic signed [dou_pkg::POS_W-1:0]    right_velocity
);

	localparam int PosW   = dou_pkg::POS_W;
	localparam int DW     = dou_pkg::DELTA_W;
	localparam int HW     = dou_pkg::HEAD_W;
	localparam int SW     = dou_pkg::SINE_W;
	localparam int TblN   = 1 << SINE_TABLE_BITS;
	localparam int VW     = $clog2(dou_pkg::HEADING_FULL * TblN);
	localparam int RShift = VW + 16;
	localparam int RW     = VW + 1;
	localparam int ProdW  = VW + RW;
	localparam int VelW   = DW + dou_pkg::GAIN_W + 1;
	localparam int MulW   = DW + SW;
	localparam int AccW   = MulW + 1;
	localparam logic [RW-1:0] RecipM = RW'(((64'd1 << RShift) +
		64'(dou_pkg::HEADING_FULL) - 64'd1) / 64'(dou_pkg::HEADING_FULL));

	function automatic logic signed [PosW-1:0] sat48(input logic signed [VelW-1:0] v);
		logic signed [PosW-1:0] r;
		if (&v[VelW-1:PosW-1] || ~|v[VelW-1:PosW-1]) begin
			r = v[PosW-1:0];
		end else begin
			r = v[VelW-1] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
		end
		return r;
	endfunction

	// handshake and stage control
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy_out, rdy_s4, rdy_s3, rdy_s2, rdy_s1;
	logic take;

	assign rdy_out      = !result_valid || !result_stall;
	assign rdy_s4       = !valid_s4 || rdy_out;
	assign rdy_s3       = !valid_s3 || rdy_s4;
	assign rdy_s2       = !valid_s2 || rdy_s3;
	assign rdy_s1       = !valid_s1 || rdy_s2;
	assign sample_stall = !rdy_s1;
	assign take         = sample_valid && rdy_s1;

	// state
	logic [dou_pkg::GAIN_W-1:0]       gain_q;
	logic signed [dou_pkg::CNT_W-1:0] last_left_q;
	logic signed [dou_pkg::CNT_W-1:0] last_right_q;
	logic signed [PosW-1:0]           acc_x_q;
	logic signed [PosW-1:0]           acc_y_q;

	assign pos_x = acc_x_q;
	assign pos_y = acc_y_q;

	// input stage logic
	logic [HW-1:0]                    head_red;
	logic signed [HW-1:0]             hs_in;
	logic signed [dou_pkg::CNT_W-1:0] base_l;
	logic signed [dou_pkg::CNT_W-1:0] base_r;
	logic signed [DW-1:0]             dl_in;
	logic signed [DW-1:0]             dr_in;

	always_comb begin
		base_l   = clear ? '0 : last_left_q;
		base_r   = clear ? '0 : last_right_q;
		dl_in    = DW'(left_count) - DW'(base_l);
		dr_in    = DW'(right_count) - DW'(base_r);
		head_red = (heading_cdeg >= HW'(dou_pkg::HEADING_FULL)) ?
			heading_cdeg - HW'(dou_pkg::HEADING_FULL) : heading_cdeg;
		hs_in    = (head_red < HW'(dou_pkg::HEADING_HALF)) ?
			$signed(head_red) : $signed(head_red - HW'(dou_pkg::HEADING_FULL));
	end

	logic                 clear_s1;
	logic [HW-1:0]        head_s1;
	logic signed [HW-1:0] hs_s1;
	logic signed [DW-1:0] dl_s1;
	logic signed [DW-1:0] dr_s1;

	// stage 2 logic: table index, mean delta, velocity products
	logic [VW-1:0]          vq;
	logic [ProdW-1:0]       idx_prod;
	logic signed [DW:0]     dsum;
	logic signed [VelW-1:0] gain_s;

	always_comb begin
		vq       = VW'({head_s1, {SINE_TABLE_BITS{1'b0}}}) + VW'(dou_pkg::HEADING_HALF);
		idx_prod = ProdW'(vq) * ProdW'(RecipM);
		dsum     = (DW+1)'(dl_s1) + (DW+1)'(dr_s1);
		gain_s   = $signed(VelW'(gain_q));
	end

	logic                       clear_s2;
	logic signed [HW-1:0]       hs_s2;
	logic [SINE_TABLE_BITS-1:0] idx_s2;
	logic signed [DW-1:0]       mean_s2;
	logic signed [VelW-1:0]     vel_l_s2;
	logic signed [VelW-1:0]     vel_r_s2;

	// stage 3 logic: sine and cosine
	dou_pkg::sincos_t sc;

	dou_sine_lut #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_lut (
		.idx(idx_s2),
		.sc (sc)
	);

	logic                   clear_s3;
	logic signed [HW-1:0]   hs_s3;
	logic signed [DW-1:0]   mean_s3;
	logic signed [SW-1:0]   sin_s3;
	logic signed [SW-1:0]   cos_s3;
	logic signed [PosW-1:0] vel_l_s3;
	logic signed [PosW-1:0] vel_r_s3;

	logic                   clear_s4;
	logic signed [HW-1:0]   hs_s4;
	logic signed [MulW-1:0] px_s4;
	logic signed [MulW-1:0] py_s4;
	logic signed [PosW-1:0] vel_l_s4;
	logic signed [PosW-1:0] vel_r_s4;

	// output stage logic: accumulate and clamp
	logic signed [AccW-1:0] sum_x;
	logic signed [AccW-1:0] sum_y;

	always_comb begin
		sum_x = (clear_s4 ? '0 : AccW'(acc_x_q)) + AccW'(px_s4);
		sum_y = (clear_s4 ? '0 : AccW'(acc_y_q)) + AccW'(py_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q       <= '0;
			last_left_q  <= '0;
			last_right_q <= '0;
			acc_x_q      <= '0;
			acc_y_q      <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			valid_s4     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (velocity_gain_we) begin
				gain_q <= velocity_gain;
			end
			if (take) begin
				last_left_q  <= left_count;
				last_right_q <= right_count;
			end
			if (rdy_s1) begin
				valid_s1 <= sample_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
			if (rdy_out) begin
				result_valid <= valid_s4;
			end
			if (rdy_out && valid_s4) begin
				acc_x_q <= sat48(VelW'(sum_x));
				acc_y_q <= sat48(VelW'(sum_y));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			clear_s1 <= clear;
			head_s1  <= head_red;
			hs_s1    <= hs_in;
			dl_s1    <= dl_in;
			dr_s1    <= dr_in;
		end
		if (rdy_s2 && valid_s1) begin
			clear_s2 <= clear_s1;
			hs_s2    <= hs_s1;
			idx_s2   <= idx_prod[RShift +: SINE_TABLE_BITS];
			mean_s2  <= DW'(dsum >>> 1);
			vel_l_s2 <= VelW'(dl_s1) * gain_s;
			vel_r_s2 <= VelW'(dr_s1) * gain_s;
		end
		if (rdy_s3 && valid_s2) begin
			clear_s3 <= clear_s2;
			hs_s3    <= hs_s2;
			mean_s3  <= mean_s2;
			sin_s3   <= sc.sin_v;
			cos_s3   <= sc.cos_v;
			vel_l_s3 <= sat48(vel_l_s2);
			vel_r_s3 <= sat48(vel_r_s2);
		end
		if (rdy_s4 && valid_s3) begin
			clear_s4 <= clear_s3;
			hs_s4    <= hs_s3;
			px_s4    <= MulW'(mean_s3) * MulW'(sin_s3);
			py_s4    <= MulW'(mean_s3) * MulW'(cos_s3);
			vel_l_s4 <= vel_l_s3;
			vel_r_s4 <= vel_r_s3;
		end
		if (rdy_out && valid_s4) begin
			heading_signed <= hs_s4;
			left_velocity  <= vel_l_s4;
			right_velocity <= vel_r_s4;
		end
	end

endmodule

FILE: hw/rtl/dou_checker.sv
// ----------------------------------------------------------------------------
// dou_checker
// Port-level checks on the result channel of the odometry update block.
// ----------------------------------------------------------------------------
`include "differential_odometry_update_assert.svh"

module dou_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              result_valid,
	input logic                              result_stall,
	input logic signed [dou_pkg::POS_W-1:0]  pos_x,
	input logic signed [dou_pkg::POS_W-1:0]  pos_y,
	input logic signed [dou_pkg::HEAD_W-1:0] heading_signed,
	input logic signed [dou_pkg::POS_W-1:0]  left_velocity,
	input logic signed [dou_pkg::POS_W-1:0]  right_velocity
);

	`DOU_ASSERT(a_valid_hold, clk, arst_n, result_valid && result_stall |=> result_valid, "result dropped while stalled")
	`DOU_ASSERT(a_beat_hold, clk, arst_n, result_valid && result_stall |=> $stable(pos_x) && $stable(pos_y) && $stable(heading_signed) && $stable(left_velocity) && $stable(right_velocity), "result beat changed while stalled")
	`DOU_ASSERT(a_heading_range, clk, arst_n, result_valid |-> (heading_signed >= -16'sd18000) && (heading_signed <= 16'sd17999), "heading out of wrap range")
	`DOU_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !result_valid, "result valid during reset")

endmodule

bind differential_odometry_update dou_checker u_dou_checker (.*);
